/* hdl/si7seg_pkg.sv */
// ----------------------------------------------------------------------------
// si7seg_pkg
// Shared types, constants and helpers for the signed seven-segment formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package si7seg_pkg;

    // display geometry
    localparam int DIGIT_COUNT = 8;
    localparam int BCD_W       = 4 * DIGIT_COUNT;

    // magnitude width: 99999999 fits in 27 bits
    localparam int MAG_W = 27;

    // double-dabble pipeline split
    localparam int STEPS_PER_STAGE = 4;
    localparam int STAGE_COUNT     = (MAG_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int LAST_STEPS      = MAG_W - (STAGE_COUNT - 1) * STEPS_PER_STAGE;

    // range limits
    localparam logic [31:0] MAX_POSITIVE = 32'd99999999;
    localparam logic [31:0] MAX_NEGATIVE = 32'd9999999;

    // segment patterns
    localparam logic [7:0] BLANK_PATTERN = 8'h00;
    localparam logic [7:0] MINUS_RESET   = 8'h02;

    // token moving down the pipeline
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic               fits;
        logic [MAG_W-1:0]   bin;
        logic [BCD_W-1:0]   bcd;
    } t_pipe;

    // one shift-add-3 step: correct each decimal digit, then shift in a bit
    function automatic t_pipe dabble_step(input t_pipe tok);
        t_pipe      res;
        logic [3:0] nib;
        res = tok;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            nib = tok.bcd[4*k +: 4];
            if (nib >= 4'd5) begin
                res.bcd[4*k +: 4] = nib + 4'd3;
            end else begin
                res.bcd[4*k +: 4] = nib;
            end
        end
        res.bcd = {res.bcd[BCD_W-2:0], tok.bin[MAG_W-1]};
        res.bin = {tok.bin[MAG_W-2:0], 1'b0};
        return res;
    endfunction

    // decimal digit to segment pattern (a..g in bits 7..1, dp off)
    function automatic logic [7:0] seg_decode(input logic [3:0] d);
        logic [7:0] pat;
        case (d)
            4'd0:    pat = 8'hfc;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hda;
            4'd3:    pat = 8'hf2;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hb6;
            4'd6:    pat = 8'hbe;
            4'd7:    pat = 8'he0;
            4'd8:    pat = 8'hfe;
            4'd9:    pat = 8'hf6;
            default: pat = BLANK_PATTERN;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

/* hdl/si7seg_front.sv */
// ----------------------------------------------------------------------------
// si7seg_front
// Input register, then sign, magnitude and range check into a token register.
// ----------------------------------------------------------------------------
`default_nettype none

module si7seg_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_number,
    output si7seg_pkg::t_pipe       o_tok
);

    logic                r_num_valid;
    logic [31:0]         r_number;
    si7seg_pkg::t_pipe   r_tok;
    si7seg_pkg::t_pipe   n_tok;
    logic [31:0]         w_mag;

    // sign, magnitude and range check
    always_comb begin
        n_tok       = '0;
        w_mag       = r_number[31] ? (~r_number + 32'd1) : r_number;
        n_tok.valid = r_num_valid;
        n_tok.neg   = r_number[31];
        n_tok.fits  = r_number[31] ? (w_mag <= si7seg_pkg::MAX_NEGATIVE)
                                   : (w_mag <= si7seg_pkg::MAX_POSITIVE);
        n_tok.bin   = w_mag[si7seg_pkg::MAG_W-1:0];
    end

    // input valid and token registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_valid <= 1'b0;
            r_tok       <= '0;
        end else if (i_adv) begin
            r_num_valid <= i_valid;
            r_tok       <= n_tok;
        end
    end

    // input number register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_number <= i_number;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hdl/si7seg_dabble.sv */
// ----------------------------------------------------------------------------
// si7seg_dabble
// One binary-to-decimal pipeline stage: STEPS shift-add-3 steps, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module si7seg_dabble #(
    parameter int STEPS = si7seg_pkg::STEPS_PER_STAGE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire si7seg_pkg::t_pipe  i_tok,
    output si7seg_pkg::t_pipe       o_tok
);

    si7seg_pkg::t_pipe r_tok;
    si7seg_pkg::t_pipe n_tok;

    // chained conversion steps
    always_comb begin
        n_tok = i_tok;
        for (int s = 0; s < STEPS; s++) begin
            n_tok = si7seg_pkg::dabble_step(n_tok);
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hdl/si7seg_display.sv */
// ----------------------------------------------------------------------------
// si7seg_display
// Segment decode with leading-zero blanking, digit buffer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module si7seg_display (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_adv,
    input  wire si7seg_pkg::t_pipe                      i_tok,
    input  wire logic                                   i_cfg_we,
    input  wire logic [7:0]                             i_cfg_wdata,
    output logic                                        o_valid,
    output logic                                        o_ok,
    output logic [8*si7seg_pkg::DIGIT_COUNT-1:0]        o_digits
);

    localparam int DC = si7seg_pkg::DIGIT_COUNT;

    logic              r_valid;
    logic              r_ok;
    logic [7:0]        r_minus_pattern;
    logic [7:0]        r_buf [DC];
    logic [7:0]        n_pat [DC];
    logic              w_seen;
    logic [3:0]        w_d;

    // decode digits, blank leading zeros, units always shown
    always_comb begin
        w_seen = 1'b0;
        w_d    = '0;
        for (int i = 0; i < DC; i++) begin
            w_d    = i_tok.bcd[4*(DC-1-i) +: 4];
            w_seen = w_seen | (w_d != 4'd0) | (i == DC - 1);
            n_pat[i] = w_seen ? si7seg_pkg::seg_decode(w_d) : si7seg_pkg::BLANK_PATTERN;
        end
        if (i_tok.neg) begin
            n_pat[0] = r_minus_pattern;
        end
    end

    // minus pattern register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minus_pattern <= si7seg_pkg::MINUS_RESET;
        end else if (i_cfg_we) begin
            r_minus_pattern <= i_cfg_wdata;
        end
    end

    // digit buffer and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            for (int i = 0; i < DC; i++) begin
                r_buf[i] <= si7seg_pkg::BLANK_PATTERN;
            end
        end else if (i_adv) begin
            r_valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_ok <= i_tok.fits;
                if (i_tok.fits) begin
                    for (int i = 0; i < DC; i++) begin
                        r_buf[i] <= n_pat[i];
                    end
                end
            end
        end
    end

    // pack buffer, digit 1 lowest
    always_comb begin
        for (int i = 0; i < DC; i++) begin
            o_digits[8*i +: 8] = r_buf[i];
        end
    end

    assign o_valid = r_valid;
    assign o_ok    = r_ok;

endmodule

`default_nettype wire

/* hdl/signed_integer_to_seven_segment_unit.sv */
// A word passes the input register, the token register, the 7-stage double-dabble
// pipeline (four shift-add-3 steps per stage, three in the last) and the result register.
// Throughput: one word per cycle while the pipeline advances.
// The whole pipeline advances together when the result register is empty or taken.
// Reset (synchronous, active low) empties the pipeline, blanks all eight digits
// and sets the minus pattern to segment g only.
// ----------------------------------------------------------------------------
// signed_integer_to_seven_segment_unit
// Formats a signed 32-bit integer onto an 8-digit seven-segment buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_seven_segment_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // slave word: [31:0] number
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [31:0]    i_s_tdata,
    // master word: [0] ok, [8:1] digit1, [16:9] digit2, ... [64:57] digit8, rest zero
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [71:0]         o_m_tdata,
    // minus pattern register
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_wdata
);

    localparam int SC = si7seg_pkg::STAGE_COUNT;

    logic                                       w_adv;
    logic                                       w_ok;
    logic [8*si7seg_pkg::DIGIT_COUNT-1:0]       w_digits;
    si7seg_pkg::t_pipe                          w_tok [SC+1];

    // global pipeline advance
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // sign and range front end
    si7seg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_s_tvalid),
        .i_number (i_s_tdata),
        .o_tok    (w_tok[0])
    );

    // binary to decimal pipeline
    for (genvar s = 0; s < SC; s++) begin : g_dabble
        si7seg_dabble #(
            .STEPS ((s == SC - 1) ? si7seg_pkg::LAST_STEPS : si7seg_pkg::STEPS_PER_STAGE)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[s]),
            .o_tok   (w_tok[s+1])
        );
    end

    // segment decode and result register
    si7seg_display u_display (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_tok       (w_tok[SC]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_m_tvalid),
        .o_ok        (w_ok),
        .o_digits    (w_digits)
    );

    assign o_m_tdata = {7'd0, w_digits, w_ok};

endmodule

`default_nettype wire
